### hw/rtl/slen_pkg.sv
// Shared types and codes for the sorted list engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package slen_pkg;

   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 4;
   localparam int COMMAND_W = 2;
   localparam int STATUS_W  = 2;

   // command codes
   localparam logic [COMMAND_W-1:0] CMD_INSERT    = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_DEL_VALUE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_DEL_INDEX = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic [COMMAND_W-1:0]      command;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
   } bcast_type;

endpackage

### hw/rtl/slen_if.sv
// Valid/ready channel interfaces for the sorted list engine.
// Depends on slen_pkg for field widths.
`timescale 1ns / 1ps

interface slen_req_if;
   import slen_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [COMMAND_W-1:0]      command;
   logic signed [VALUE_W-1:0] value;
   logic [INDEX_W-1:0]        index;

   modport source (output valid, command, value, index, input ready);
   modport sink   (input valid, command, value, index, output ready);
endinterface

interface slen_rsp_if #(parameter int CNT_W = 5);
   import slen_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    count_after;

   modport source (output valid, status, count_after, input ready);
   modport sink   (input valid, status, count_after, output ready);
endinterface

### hw/rtl/slen_cell.sv
// One position of the sorted row: holds one entry and shifts with its neighbors.
// Depends on slen_pkg for the broadcast type and command codes.
`timescale 1ns / 1ps

module slen_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  slen_pkg::bcast_type                bcast,
   input  logic [CNT_W-1:0]                   count,
   input  logic                               write_en,
   input  logic signed [slen_pkg::VALUE_W-1:0] left_entry,
   input  logic                               left_shift,
   input  logic signed [slen_pkg::VALUE_W-1:0] right_entry,
   output logic signed [slen_pkg::VALUE_W-1:0] entry,
   output logic                               shift,
   output logic                               found
);
   import slen_pkg::*;

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      occupied;
   logic                      value_less;
   logic                      ins_mark;
   logic                      del_mark;

   assign occupied   = CNT_W'(INDEX) < count;
   assign value_less = bcast.value < entry_ff;

   // insert point and everything above it move up
   assign ins_mark = !occupied || value_less;

   always_comb begin
      del_mark = 1'b0;
      case (bcast.command)
         CMD_DEL_VALUE: del_mark = occupied && !(entry_ff < bcast.value);
         CMD_DEL_INDEX: del_mark = INDEX >= int'(bcast.index);
         default:       del_mark = 1'b0;
      endcase
   end

   // first cell at or above the value, and equal to it
   assign found = (bcast.command == CMD_DEL_VALUE) && del_mark && !left_shift &&
                  (entry_ff == bcast.value);

   assign shift = (bcast.command == CMD_INSERT) ? ins_mark : del_mark;

   always_comb begin
      entry_in = entry_ff;
      if (bcast.command == CMD_INSERT) begin
         if (ins_mark) begin
            entry_in = left_shift ? left_entry : bcast.value;
         end
      end else if (del_mark) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/sorted_list_engine_unit.sv
// Top level of the sorted list engine: command channel, result channel, cell row.
// Depends on slen_pkg, slen_if (channel interfaces) and slen_cell.
`timescale 1ns / 1ps

// Sorted list engine.
// Keeps up to DEPTH signed 32-bit values in ascending order in a row of cells.
// Commands arrive on req_ch (command, value, index); each transfer yields
// exactly one result on rsp_ch (status, count_after).
//   insert       : value goes after all equal entries, larger ones move up;
//                  a full list reports full and stores nothing.
//   delete value : the lowest equal entry is removed and the gap closes;
//                  an absent value reports not found.
//   delete index : the entry at index is removed; index at or past the count
//                  reports out of range. The unused code is a no-op.
// Every cell compares itself against the broadcast command and takes its own,
// left or right neighbor's entry in the same cycle, so the whole row updates at
// once: the result is visible in the cycle after the request transfer, and one
// command per cycle is sustained while rsp_ch.ready stays high. That rate is set
// by the update of the whole row at once and the one-deep result register.
// A stalled receiver holds the result register; req_ch.ready stays high while
// the result register is empty or is being taken, so no result is dropped.
// Reset clears the count and the result valid only; cell contents stay as
// they are and are ignored above the count, so no clearing pass is needed.

module sorted_list_engine_unit #(
   parameter int DEPTH = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic           clock,
   input  logic           reset,
   slen_req_if.sink       req_ch,
   slen_rsp_if.source     rsp_ch
);
   import slen_pkg::*;

   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   bcast_type            bcast;
   logic                 req_xfer;
   logic                 write_en;
   logic                 found_any;
   logic                 ins_ok;
   logic                 range_ok;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [STATUS_W-1:0]  status_in;
   logic [CNT_W-1:0]     count_after_ff;

   logic signed [VALUE_W-1:0] entry_w [DEPTH];
   logic [DEPTH-1:0]          shift_w;
   logic [DEPTH-1:0]          found_w;

   assign bcast.command = req_ch.command;
   assign bcast.value   = req_ch.value;
   assign bcast.index   = req_ch.index;

   // accept while the result register is empty or draining
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry;
      logic                      left_shift;
      logic signed [VALUE_W-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_shift = 1'b0;
      end else begin : g_inner_left
         assign left_entry = entry_w[i-1];
         assign left_shift = shift_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry_w[i];
      end else begin : g_inner_right
         assign right_entry = entry_w[i+1];
      end

      slen_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .bcast       (bcast),
         .count       (count_ff),
         .write_en    (write_en),
         .left_entry  (left_entry),
         .left_shift  (left_shift),
         .right_entry (right_entry),
         .entry       (entry_w[i]),
         .shift       (shift_w[i]),
         .found       (found_w[i])
      );
   end

   assign found_any = |found_w;
   assign ins_ok    = count_ff < CNT_W'(DEPTH);
   assign range_ok  = CMP_W'(req_ch.index) < CMP_W'(count_ff);

   // decide status and commit
   always_comb begin
      status_in = ST_DONE;
      count_in  = count_ff;
      write_en  = 1'b0;
      case (req_ch.command)
         CMD_INSERT: begin
            if (ins_ok) begin
               write_en = req_xfer;
               count_in = count_ff + CNT_W'(1);
            end else begin
               status_in = ST_FULL;
            end
         end
         CMD_DEL_VALUE: begin
            if (found_any) begin
               write_en = req_xfer;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         CMD_DEL_INDEX: begin
            if (range_ok) begin
               write_en = req_xfer;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status_in = ST_RANGE;
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload; hold while stalled
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff      <= status_in;
         count_after_ff <= count_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.count_after = count_after_ff;

   // count stays within the row
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count exceeds depth");

   // at most one cell claims the first match
   a_found_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(found_w))
      else $error("more than one first match");

   // an accepted insert with room grows the list by one
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_ch.command == CMD_INSERT && ins_ok
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow count");

   // a transfer always leaves a result behind
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("result missing after transfer");

   // full is only reported at full depth
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FULL |-> count_after_ff == CNT_W'(DEPTH))
      else $error("full status below depth");

endmodule

### tb/slen_tb_pkg.sv
// Scoreboard for the sorted list engine testbench: predicts each result and checks it.
// Depends on slen_pkg for field widths, command codes and status codes.
`timescale 1ns / 1ps

package slen_tb_pkg;
   import slen_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);

   // the one code the block does not define: treated as a no-op
   localparam logic [COMMAND_W-1:0] CMD_UNUSED = 2'd3;

   class list_scoreboard;
      typedef struct packed {
         logic [STATUS_W-1:0] status;
         logic [COUNT_W-1:0]  count_after;
      } outcome_type;

      logic signed [VALUE_W-1:0] entries[$];
      outcome_type               awaiting[$];
      int                        depth;
      int                        errors;

      function new(int depth);
         this.depth = depth;
         errors     = 0;
      endfunction

      // apply one accepted command to the shadow list and queue its outcome
      function void note_command(logic [COMMAND_W-1:0] command,
                                 logic signed [VALUE_W-1:0] value,
                                 logic [INDEX_W-1:0] index);
         outcome_type o;
         int          pos;
         int          i;
         o.status = ST_DONE;
         case (command)
            CMD_INSERT: begin
               if (entries.size() >= depth) begin
                  o.status = ST_FULL;
               end else begin
                  pos = entries.size();
                  for (i = 0; i < entries.size(); i++) begin
                     if (value < entries[i]) begin
                        pos = i;
                        break;
                     end
                  end
                  entries.insert(pos, value);
               end
            end
            CMD_DEL_VALUE: begin
               pos = -1;
               for (i = 0; i < entries.size(); i++) begin
                  if (entries[i] == value) begin
                     pos = i;
                     break;
                  end
               end
               if (pos < 0) o.status = ST_NOT_FOUND;
               else entries.delete(pos);
            end
            CMD_DEL_INDEX: begin
               if (index < entries.size()) entries.delete(index);
               else o.status = ST_RANGE;
            end
            default: ;
         endcase
         o.count_after = COUNT_W'(entries.size());
         awaiting.push_back(o);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status,
                                 logic [COUNT_W-1:0] count_after);
         outcome_type o;
         if (awaiting.size() == 0) begin
            $error("result with no command waiting: status %0d count_after %0d",
                   status, count_after);
            errors++;
            return;
         end
         o = awaiting.pop_front();
         if (status !== o.status) begin
            $error("status: expected %0d, actual %0d", o.status, status);
            errors++;
         end
         if (count_after !== o.count_after) begin
            $error("count_after: expected %0d, actual %0d", o.count_after, count_after);
            errors++;
         end
      endfunction

      function int pending();
         return awaiting.size();
      endfunction
   endclass

endpackage

### tb/sorted_list_engine_unit_tb.sv
// Top-level testbench for sorted_list_engine_unit: directed and random command streams.
// Depends on slen_pkg, slen_if, slen_tb_pkg (scoreboard) and the block's RTL.
`timescale 1ns / 1ps

module sorted_list_engine_unit_tb;
   import slen_pkg::*;
   import slen_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 194;

   logic clock;
   logic reset;

   slen_req_if                   req_ch ();
   slen_rsp_if #(.CNT_W(COUNT_W)) rsp_ch ();

   sorted_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_scoreboard sb;

   int cycle_count = 0;
   // idling knobs, retuned per phase; zero gives a stretch with no idling
   int req_gap_pct;
   int rsp_stall_pct;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   // Values: extremes, a narrow band that breeds duplicates, or anything at all.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r == 0) begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      if (r <= 4) return $signed($urandom_range(15)) - 8;
      return $signed($urandom);
   endfunction

   // Pick a value that is in the list most of the time, so deletes hit.
   function automatic logic signed [VALUE_W-1:0] pick_search_value();
      if (sb.entries.size() > 0 && $urandom_range(9) < 7)
         return sb.entries[$urandom_range(sb.entries.size() - 1)];
      return pick_value();
   endfunction

   // Result side: stall ready in bursts; hold it low across a chosen gap.
   initial begin
      int stall_left;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if ($urandom_range(99) < rsp_stall_pct) begin
            stall_left = pick_gap() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Check every result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.status, rsp_ch.count_after);
   end

   // Drive one command, wait for its transfer, record it, then maybe idle.
   // Called at a rising edge; valid stays high into the next command when
   // no gap is chosen, so it is never lowered and raised in one step.
   task automatic push_command(input logic [COMMAND_W-1:0] command,
                               input logic signed [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.command <= command;
      req_ch.value   <= value;
      req_ch.index   <= index;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_command(command, value, index);
      if ($urandom_range(99) < req_gap_pct) begin
         gap = pick_gap();
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // One random command; insert_pct sets how hard the phase pushes the list up.
   task automatic push_random_command(input int insert_pct);
      int                        r;
      logic [COMMAND_W-1:0]      command;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      r     = $urandom_range(99);
      index = INDEX_W'($urandom_range(15));
      if (r < insert_pct) begin
         command = CMD_INSERT;
         value   = pick_value();
      end else if (r < insert_pct + 3) begin
         command = CMD_UNUSED;
         value   = $signed($urandom);
      end else if (r % 2 == 0) begin
         command = CMD_DEL_VALUE;
         value   = pick_search_value();
      end else begin
         command = CMD_DEL_INDEX;
         value   = $signed($urandom);
         // mostly a live position, sometimes anywhere to hit out of range
         if (sb.entries.size() > 0 && $urandom_range(9) < 8)
            index = INDEX_W'($urandom_range(sb.entries.size() - 1));
      end
      push_command(command, value, index);
   endtask

   initial begin
      int insert_pcts[RANDOM_PHASES];
      int p;
      int n;

      insert_pcts    = '{80, 30, 55, 90, 20, 55, 70, 40};
      sb             = new(LIST_DEPTH);
      req_gap_pct    = 25;
      rsp_stall_pct  = 20;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_INSERT;
      req_ch.value   = '0;
      req_ch.index   = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list misses, the no-op code, extremes and duplicates.
      push_command(CMD_DEL_VALUE, 32'sd5, 4'd0);
      push_command(CMD_DEL_INDEX, 32'sd0, 4'd0);
      push_command(CMD_UNUSED, 32'sh7fff_ffff, 4'd15);
      push_command(CMD_INSERT, 32'sh7fff_ffff, 4'd0);
      push_command(CMD_INSERT, 32'sh8000_0000, 4'd0);
      push_command(CMD_INSERT, 32'sd0, 4'd0);
      push_command(CMD_INSERT, -32'sd1, 4'd0);
      // equal value lands after the existing zero
      push_command(CMD_INSERT, 32'sd0, 4'd0);
      push_command(CMD_INSERT, 32'sd1, 4'd0);
      // remove the first of the two zeros
      push_command(CMD_DEL_VALUE, 32'sd0, 4'd0);
      // index past the count
      push_command(CMD_DEL_INDEX, 32'sd0, 4'd15);
      // remove the smallest entry
      push_command(CMD_DEL_INDEX, 32'sd0, 4'd0);
      // fill the list, then insert once more into a full list
      for (n = 0; n < LIST_DEPTH - 4; n++) push_command(CMD_INSERT, pick_value(), 4'd0);
      push_command(CMD_INSERT, 32'sd3, 4'd0);
      // remove the top position of a full list
      push_command(CMD_DEL_INDEX, 32'sd0, 4'd15);
      drain_results();

      // Random phases: shift the insert/delete balance so the list sweeps
      // between empty and full; some phases run with no idling at all.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         req_gap_pct   = (p % 4 == 1) ? 0 : 25;
         rsp_stall_pct = (p % 4 == 1 || p % 4 == 2) ? 0 : 20;
         for (n = 0; n < PHASE_ITEMS; n++) push_random_command(insert_pcts[p]);
         // hold off the sender until every result is back
         if (p % 2 == 0) drain_results();
      end

      // Wait out the tail, idle on for stray results, then report.
      drain_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
